// ----- rtl/core/gdcl_pkg.sv -----
// Types and constants shared by the garage door code lock controller.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gdcl_pkg;

    localparam int MAX_CODE_LENGTH = 8;
    localparam int KEY_IDX_W       = 4;
    localparam int KEY_CODE_W      = 5;
    localparam int DIST_W          = 9;
    localparam int COUNT_W         = 3;
    localparam int TIMER_W         = 16;
    localparam int CFG_INDEX_W     = 3;
    localparam int CFG_DATA_W      = 16;

    // Smallest and largest keypad positions that carry a key.
    localparam logic [KEY_CODE_W-1:0] KEY_FIRST = 5'd1;
    localparam logic [KEY_CODE_W-1:0] KEY_LAST  = 5'd16;

    // Configuration register indices.
    localparam logic [CFG_INDEX_W-1:0] CFG_CODE_KEYS       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_APPROACH_LIMIT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INNER_LIMIT     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_ATTEMPTS    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCKOUT_TICKS   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ARRIVAL_TIMEOUT = 3'd5;

    // Configuration reset values.
    localparam logic [15:0]        RST_CODE_KEYS       = 16'd16912;
    localparam logic [DIST_W-1:0]  RST_APPROACH_LIMIT  = 9'd25;
    localparam logic [DIST_W-1:0]  RST_INNER_LIMIT     = 9'd15;
    localparam logic [COUNT_W-1:0] RST_MAX_ATTEMPTS    = 3'd3;
    localparam logic [TIMER_W-1:0] RST_LOCKOUT_TICKS   = 16'd288;
    localparam logic [TIMER_W-1:0] RST_ARRIVAL_TIMEOUT = 16'd100;

    typedef enum logic [2:0] {
        MODE_IDLE         = 3'd0,
        MODE_ENTRY        = 3'd1,
        MODE_LOCKOUT      = 3'd2,
        MODE_AWAIT_INNER  = 3'd3,
        MODE_OUTER_CLEAR  = 3'd4,
        MODE_EXIT_AWAIT   = 3'd5,
        MODE_EXIT_CLEAR   = 3'd6
    } mode_t;

    typedef enum logic [1:0] {
        EVT_NONE    = 2'd0,
        EVT_CORRECT = 2'd1,
        EVT_WRONG   = 2'd2
    } code_event_t;

    typedef struct packed {
        logic [TIMER_W-1:0] arrival_timeout_ticks;
        logic [TIMER_W-1:0] lockout_ticks;
        logic [COUNT_W-1:0] max_attempts;
        logic [DIST_W-1:0]  inner_limit_cm;
        logic [DIST_W-1:0]  approach_limit_cm;
        logic [15:0]        code_keys;
    } cfg_t;

    // Packed so that the last field sits in the lowest bits.
    typedef struct packed {
        logic [KEY_CODE_W-1:0] key_code;
        logic                  exit_button;
        logic [DIST_W-1:0]     inner_cm;
        logic [DIST_W-1:0]     outer_cm;
    } sample_t;

    typedef struct packed {
        logic [TIMER_W-1:0] lockout_left;
        logic [1:0]         code_event;
        logic [COUNT_W-1:0] keys_entered;
        logic [2:0]         phase;
        logic               green_led;
        logic               red_led;
        logic               door_open;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/garage_door_code_lock_controller_unit.sv -----
// Garage door code lock controller, top level: input register, state machine, result register.
// Depends on gdcl_pkg, gdcl_cfg_regs and gdcl_fsm.
//
// Usage. Each request on the s_ channel is one control tick: the outer and
// inner distance readings, the exit button level and the keypad key clicked.
// Every request yields exactly one result on the m_ channel: door command,
// lamps, phase, keys collected, code event and lockout ticks remaining.
// The configuration channel writes one register per handshake; cfg_ready is
// always high, and writes should only be issued with no request in flight.
//
// Pipeline. A request that is accepted is held in the input register; once the
// result register is free the state machine updates and loads the result
// register, which then offers the result. One request is taken per cycle
// while m_tready does not stall the result register.
//
// Reset. A synchronous low aresetn empties both registers, returns the state
// machine to idle with the door shut and restores the register defaults.
// Stall. While m_tready is low the result holds; the input register still
// takes one more request, after which s_tready falls until the result leaves.
`default_nettype none

module garage_door_code_lock_controller_unit
    import gdcl_pkg::*;
#(
    parameter int CODE_LENGTH = 4
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    // Configuration writes.
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    // Ticks in.
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // s_tdata, low bit up: outer_cm[8:0], inner_cm[17:9], exit_button[18], key_code[23:19]
    input  wire logic [23:0]            s_tdata,
    // Results out.
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // m_tdata, low bit up: door_open[0], red_led[1], green_led[2], phase[5:3],
    // keys_entered[8:6], code_event[10:9], lockout_left[26:11], zero[31:27]
    output logic [31:0]                 m_tdata
);

    cfg_t    cfg;
    sample_t in_data_reg;
    logic    in_valid_reg, in_valid_next;
    result_t out_data_reg;
    logic    out_valid_reg, out_valid_next;
    result_t result;
    logic    out_free;
    logic    advance;

    assign cfg_ready = 1'b1;

    gdcl_cfg_regs u_cfg_regs (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    gdcl_fsm #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_fsm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .cfg     (cfg),
        .sample  (in_data_reg),
        .result  (result)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= sample_t'(s_tdata);
        end
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = 32'(out_data_reg);

endmodule

`default_nettype wire

// ----- rtl/core/gdcl_cfg_regs.sv -----
// Configuration register file of the garage door code lock controller.
// Depends on gdcl_pkg for register indices, reset values and cfg_t.
`default_nettype none

module gdcl_cfg_regs
    import gdcl_pkg::*;
(
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   wr_en,
    input  wire logic [CFG_INDEX_W-1:0] wr_index,
    input  wire logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (wr_index)
                CFG_CODE_KEYS:       cfg_next.code_keys = wr_data;
                CFG_APPROACH_LIMIT:  cfg_next.approach_limit_cm = wr_data[DIST_W-1:0];
                CFG_INNER_LIMIT:     cfg_next.inner_limit_cm = wr_data[DIST_W-1:0];
                CFG_MAX_ATTEMPTS:    cfg_next.max_attempts = wr_data[COUNT_W-1:0];
                CFG_LOCKOUT_TICKS:   cfg_next.lockout_ticks = wr_data[TIMER_W-1:0];
                CFG_ARRIVAL_TIMEOUT: cfg_next.arrival_timeout_ticks = wr_data[TIMER_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.code_keys             <= RST_CODE_KEYS;
            cfg_reg.approach_limit_cm     <= RST_APPROACH_LIMIT;
            cfg_reg.inner_limit_cm        <= RST_INNER_LIMIT;
            cfg_reg.max_attempts          <= RST_MAX_ATTEMPTS;
            cfg_reg.lockout_ticks         <= RST_LOCKOUT_TICKS;
            cfg_reg.arrival_timeout_ticks <= RST_ARRIVAL_TIMEOUT;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- rtl/core/gdcl_fsm.sv -----
// Door control state machine: one tick per advance, result formed from next state.
// Depends on gdcl_pkg for mode_t, code_event_t, cfg_t, sample_t and result_t.
`default_nettype none

module gdcl_fsm
    import gdcl_pkg::*;
#(
    parameter int CODE_LENGTH = 4
) (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    advance,
    input  wire cfg_t    cfg,
    input  wire sample_t sample,
    output result_t      result
);

    localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [COUNT_W:0] CODE_LEN_W = (COUNT_W + 1)'(CODE_LENGTH);

    mode_t                mode_reg, mode_next;
    logic                 door_reg, door_next;
    logic [COUNT_W-1:0]   key_count_reg, key_count_next;
    logic [COUNT_W-1:0]   wrong_count_reg, wrong_count_next;
    logic [TIMER_W-1:0]   wait_timer_reg, wait_timer_next;
    logic [KEY_IDX_W-1:0] typed_keys_reg  [CODE_LENGTH];
    logic [KEY_IDX_W-1:0] typed_keys_next [CODE_LENGTH];

    logic                      outer_near;
    logic                      inner_near;
    logic                      key_valid;
    logic [KEY_CODE_W-1:0]     key_minus_one;
    logic [COUNT_W:0]          count_inc;
    logic [COUNT_W-1:0]        wrong_inc;
    logic [TIMER_W:0]          timer_inc;
    logic                      wait_expired;
    logic [4*MAX_CODE_LENGTH-1:0] code_ext;
    logic                      code_match;
    code_event_t               code_event;

    assign outer_near    = sample.outer_cm <= cfg.approach_limit_cm;
    assign inner_near    = sample.inner_cm <= cfg.inner_limit_cm;
    assign key_valid     = (sample.key_code >= KEY_FIRST) && (sample.key_code <= KEY_LAST);
    assign key_minus_one = sample.key_code - KEY_FIRST;
    assign count_inc     = {1'b0, key_count_reg} + 1'b1;
    assign wrong_inc     = wrong_count_reg + 1'b1;
    assign timer_inc     = {1'b0, wait_timer_reg} + 1'b1;
    assign wait_expired  = timer_inc > {1'b0, cfg.arrival_timeout_ticks};
    // Code nibbles beyond the register's four read as zero.
    assign code_ext      = (4 * MAX_CODE_LENGTH)'(cfg.code_keys);

    // The key being typed takes part in the comparison on the same tick.
    always_comb begin
        for (int i = 0; i < CODE_LENGTH; i++) begin
            typed_keys_next[i] = typed_keys_reg[i];
            if (mode_reg == MODE_ENTRY && key_valid
                    && key_count_reg[IDX_W-1:0] == IDX_W'(i)) begin
                typed_keys_next[i] = key_minus_one[KEY_IDX_W-1:0];
            end
        end
    end

    always_comb begin
        code_match = 1'b1;
        for (int i = 0; i < CODE_LENGTH; i++) begin
            if (typed_keys_next[i] != code_ext[4*i +: 4]) begin
                code_match = 1'b0;
            end
        end
    end

    always_comb begin
        mode_next        = mode_reg;
        door_next        = door_reg;
        key_count_next   = key_count_reg;
        wrong_count_next = wrong_count_reg;
        wait_timer_next  = wait_timer_reg;
        code_event       = EVT_NONE;
        case (mode_reg)
            MODE_ENTRY: begin
                if (key_valid) begin
                    if (count_inc >= CODE_LEN_W) begin
                        key_count_next = '0;
                        if (code_match) begin
                            code_event       = EVT_CORRECT;
                            wrong_count_next = '0;
                            door_next        = 1'b1;
                            wait_timer_next  = '0;
                            mode_next        = MODE_AWAIT_INNER;
                        end else begin
                            code_event       = EVT_WRONG;
                            wrong_count_next = wrong_inc;
                            if (wrong_inc >= cfg.max_attempts) begin
                                wait_timer_next = cfg.lockout_ticks;
                                mode_next       = MODE_LOCKOUT;
                            end
                        end
                    end else begin
                        key_count_next = count_inc[COUNT_W-1:0];
                    end
                end
            end
            MODE_LOCKOUT: begin
                if (wait_timer_reg <= TIMER_W'(1)) begin
                    wait_timer_next  = '0;
                    wrong_count_next = '0;
                    mode_next        = MODE_ENTRY;
                end else begin
                    wait_timer_next = wait_timer_reg - 1'b1;
                end
            end
            MODE_AWAIT_INNER: begin
                // The timer only moves on ticks where the sensor has not fired.
                if (inner_near || wait_expired) begin
                    mode_next = MODE_OUTER_CLEAR;
                end else begin
                    wait_timer_next = timer_inc[TIMER_W-1:0];
                end
            end
            MODE_OUTER_CLEAR: begin
                if (!outer_near) begin
                    door_next = 1'b0;
                    mode_next = MODE_IDLE;
                end
            end
            MODE_EXIT_AWAIT: begin
                if (outer_near || wait_expired) begin
                    mode_next = MODE_EXIT_CLEAR;
                end else begin
                    wait_timer_next = timer_inc[TIMER_W-1:0];
                end
            end
            MODE_EXIT_CLEAR: begin
                if (!outer_near && !inner_near) begin
                    door_next = 1'b0;
                    mode_next = MODE_IDLE;
                end
            end
            default: begin
                // Idle, and any unused code, behaves as idle with the door shut.
                mode_next = MODE_IDLE;
                door_next = 1'b0;
                if (outer_near) begin
                    key_count_next   = '0;
                    wrong_count_next = '0;
                    mode_next        = MODE_ENTRY;
                end else if (sample.exit_button) begin
                    door_next       = 1'b1;
                    wait_timer_next = '0;
                    mode_next       = MODE_EXIT_AWAIT;
                end
            end
        endcase

        result.door_open    = door_next;
        result.red_led      = !door_next;
        result.green_led    = door_next;
        result.phase        = mode_next;
        result.keys_entered = key_count_next;
        result.code_event   = code_event;
        result.lockout_left = (mode_next == MODE_LOCKOUT) ? wait_timer_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= MODE_IDLE;
            door_reg        <= 1'b0;
            key_count_reg   <= '0;
            wrong_count_reg <= '0;
            wait_timer_reg  <= '0;
        end else if (advance) begin
            mode_reg        <= mode_next;
            door_reg        <= door_next;
            key_count_reg   <= key_count_next;
            wrong_count_reg <= wrong_count_next;
            wait_timer_reg  <= wait_timer_next;
        end
    end

    // Typed keys are always written before they are compared, so no reset.
    always_ff @(posedge aclk) begin
        if (advance) begin
            typed_keys_reg <= typed_keys_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/gdcl_checker.sv -----
// Port-level checks for the garage door code lock controller, bound to the top level.
// Depends on gdcl_pkg for phase and event codes.
`default_nettype none

module gdcl_checker
    import gdcl_pkg::*;
(
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    // No result may be offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered straight after reset");

    // A stalled result must hold.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Lamps follow the door command.
    a_lamps: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2] == m_tdata[0]) && (m_tdata[1] != m_tdata[0]))
        else $error("lamps disagree with door command");

    // A correct code opens the door and starts waiting for the inner sensor.
    a_correct_opens: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[10:9] == EVT_CORRECT |-> m_tdata[0]
            && m_tdata[5:3] == MODE_AWAIT_INNER)
        else $error("correct code without door opening");

    // Lockout ticks show only while locked out.
    a_lockout_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[26:11] != 16'd0 |-> m_tdata[5:3] == MODE_LOCKOUT)
        else $error("lockout count outside lockout");

endmodule

bind garage_door_code_lock_controller_unit gdcl_checker u_gdcl_checker (.*);

`default_nettype wire
